### design/chr_pkg.sv
package chr_pkg;

	// Command codes.
	localparam logic [1:0] CMD_ADD    = 2'd0;
	localparam logic [1:0] CMD_REMOVE = 2'd1;
	localparam logic [1:0] CMD_LOOKUP = 2'd2;
	localparam logic [1:0] CMD_RSVD   = 2'd3;

	// Status codes.
	localparam logic [2:0] ST_OK     = 3'd0;
	localparam logic [2:0] ST_EMPTY  = 3'd1;
	localparam logic [2:0] ST_DUP    = 3'd2;
	localparam logic [2:0] ST_ABSENT = 3'd3;
	localparam logic [2:0] ST_FULL   = 3'd4;

	// Replica generator constants.
	localparam logic [63:0] PCG_MULT = 64'd6364136223846793005;
	localparam logic [63:0] PCG_INC  = 64'd1442695040888963407;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [63:0] node_key;
		logic [31:0] node_hash;
		logic [31:0] query_hash;
	} chr_req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [63:0] owner_key;
	} chr_resp_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_DISPATCH,
		S_SEED,
		S_REP_CHECK,
		S_REP_SCAN,
		S_REP_DRAIN,
		S_REP_WRITE,
		S_REM_SCAN,
		S_REM_DRAIN,
		S_REM_FIN,
		S_LKP_SCAN,
		S_LKP_DRAIN,
		S_LKP_FIN
	} chr_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       load_req;
		logic       clr_en;
		logic       mul_start;
		logic       mul_seed;
		logic       st_load;
		logic       scan_init;
		logic       scan_en;
		logic       place_commit;
		logic       node_add;
		logic       slot_found;
		logic       node_del;
		logic       resp_load;
		logic [2:0] resp_status;
		logic       resp_owner;
	} chr_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [1:0] cmd;
		logic       ptr_last;
		logic       mul_rdy;
		logic       dup;
		logic       full;
		logic       absent;
		logic       rep_done;
		logic       ring_hit;
	} chr_stat_t;

endpackage

### design/chr_mul64.sv
module chr_mul64 import chr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] a,
	output logic        rdy,
	output logic [63:0] prod
);

	logic [1:0]  ph_q;
	logic [63:0] a_q;
	logic [63:0] lo_q;
	logic [31:0] mid_q;
	logic [63:0] prod_q;
	logic [31:0] op_x;
	logic [31:0] op_y;
	logic [63:0] pp;

	// One shared 32x32 multiplier, one partial product per phase.
	always_comb begin
		unique case (ph_q)
			2'd2:    begin op_x = a_q[31:0];  op_y = PCG_MULT[63:32]; end
			2'd3:    begin op_x = a_q[63:32]; op_y = PCG_MULT[31:0];  end
			default: begin op_x = a_q[31:0];  op_y = PCG_MULT[31:0];  end
		endcase
		pp = {32'd0, op_x} * {32'd0, op_y};
	end

	// Phase counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= 2'd0;
		end else if (ph_q == 2'd0) begin
			if (start) ph_q <= 2'd1;
		end else begin
			ph_q <= ph_q + 2'd1;
		end
	end

	// Operand and partial product registers.
	always_ff @(posedge clk) begin
		if (ph_q == 2'd0 && start) a_q <= a;
		if (ph_q == 2'd1) lo_q <= pp;
		if (ph_q == 2'd2) mid_q <= pp[31:0];
		if (ph_q == 2'd3) prod_q <= lo_q + {mid_q + pp[31:0], 32'd0};
	end

	assign rdy  = (ph_q == 2'd0);
	assign prod = prod_q;

endmodule

### design/chr_datapath.sv
module chr_datapath import chr_pkg::*; #(
	parameter int MAX_NODES    = 16,
	parameter int MAX_REPLICAS = 64,
	parameter int MAX_POINTS   = 1024
) (
	input  logic       clk,
	input  logic       arst_n,
	input  chr_req_t   req,
	input  logic [6:0] num_replicas,
	input  chr_cmd_t   cmd,
	output chr_stat_t  stat,
	output logic       done,
	output chr_resp_t  resp
);

	localparam int NW = $clog2(MAX_NODES);
	localparam int PW = $clog2(MAX_POINTS);
	localparam int CW = $clog2(MAX_REPLICAS + 1);
	localparam int MW = 1 + NW + 32;

	chr_req_t           req_q;
	logic [63:0]        keys_q [MAX_NODES];
	logic [MAX_NODES-1:0] used_q;
	logic [NW-1:0]      slot_q;
	logic [63:0]        st_q;
	logic [CW-1:0]      rep_q;
	logic [CW-1:0]      rep_lim;
	logic [PW-1:0]      ptr_q;
	logic               rd_v_s1;
	logic [PW-1:0]      addr_s1;
	logic [MW-1:0]      rd_s1;
	logic [MW-1:0]      mem [MAX_POINTS];
	logic               done_q;
	chr_resp_t          resp_q;

	// Scan trackers.
	logic               mt_v_q;
	logic [PW-1:0]      mt_a_q;
	logic [NW-1:0]      mt_n_q;
	logic               fr_v_q;
	logic [PW-1:0]      fr_a_q;
	logic               lo_v_q;
	logic [31:0]        lo_h_q;
	logic [NW-1:0]      lo_n_q;
	logic               ab_v_q;
	logic [31:0]        ab_h_q;
	logic [NW-1:0]      ab_n_q;

	logic               hit_any;
	logic [NW-1:0]      hit_idx;
	logic               free_any;
	logic [NW-1:0]      free_idx;
	logic [31:0]        xs;
	logic [63:0]        rot_dbl;
	logic [31:0]        rep_h;
	logic [63:0]        mul_a;
	logic               mul_rdy;
	logic [63:0]        mul_p;
	logic [NW-1:0]      own_idx;
	logic [63:0]        own_key;
	logic               rd_used;
	logic [NW-1:0]      rd_node;
	logic [31:0]        rd_hash;
	logic               we;
	logic [PW-1:0]      wa;
	logic [MW-1:0]      wd;

	// Node table match and lowest free slot.
	always_comb begin
		hit_any  = 1'b0;
		hit_idx  = '0;
		free_any = 1'b0;
		free_idx = '0;
		for (int i = 0; i < MAX_NODES; i++) begin
			if (used_q[i] && keys_q[i] == req_q.node_key) begin
				hit_any = 1'b1;
				hit_idx = hit_idx | NW'(i);
			end
		end
		for (int i = MAX_NODES - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				free_any = 1'b1;
				free_idx = NW'(i);
			end
		end
	end

	// Replica hash from the current generator state.
	always_comb begin
		xs      = 32'(((st_q >> 18) ^ st_q) >> 27);
		rot_dbl = {xs, xs} >> st_q[63:59];
		rep_h   = rot_dbl[31:0];
	end

	assign mul_a = cmd.mul_seed ? ({32'd0, req_q.node_hash} + PCG_INC) : st_q;

	chr_mul64 u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.mul_start),
		.a     (mul_a),
		.rdy   (mul_rdy),
		.prod  (mul_p)
	);

	// Clamp of the replica count.
	always_comb begin
		if (32'(num_replicas) > MAX_REPLICAS) rep_lim = CW'(MAX_REPLICAS);
		else rep_lim = CW'(num_replicas);
	end

	// Request and node table registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else begin
			if (cmd.node_add) used_q[free_idx] <= 1'b1;
			if (cmd.node_del) used_q[slot_q] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) req_q <= req;
		if (cmd.node_add) begin
			keys_q[free_idx] <= req_q.node_key;
			slot_q <= free_idx;
		end
		if (cmd.slot_found) slot_q <= hit_idx;
		if (cmd.st_load) st_q <= mul_p + PCG_INC;
	end

	// Replica counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rep_q <= '0;
		else if (cmd.node_add) rep_q <= '0;
		else if (cmd.place_commit) rep_q <= rep_q + CW'(1);
	end

	// Point address pointer and read stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q   <= '0;
			rd_v_s1 <= 1'b0;
		end else begin
			rd_v_s1 <= cmd.scan_en;
			if (cmd.scan_en || cmd.clr_en) begin
				if (ptr_q == PW'(MAX_POINTS - 1)) ptr_q <= '0;
				else ptr_q <= ptr_q + PW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_en) begin
			rd_s1   <= mem[ptr_q];
			addr_s1 <= ptr_q;
		end
	end

	assign rd_used = rd_s1[MW-1];
	assign rd_node = rd_s1[32 +: NW];
	assign rd_hash = rd_s1[31:0];

	// Node key read for the owner compare or the lookup answer.
	assign own_idx = (req_q.cmd == CMD_LOOKUP) ? (ab_v_q ? ab_n_q : lo_n_q) : mt_n_q;
	assign own_key = keys_q[own_idx];

	// Point memory write port.
	always_comb begin
		we = 1'b0;
		wa = ptr_q;
		wd = '0;
		priority if (cmd.clr_en) begin
			we = 1'b1;
		end else if (rd_v_s1 && req_q.cmd == CMD_REMOVE) begin
			we = rd_used && rd_node == slot_q;
			wa = addr_s1;
		end else if (cmd.place_commit) begin
			wd = {1'b1, slot_q, rep_h};
			if (mt_v_q) begin
				we = req_q.node_key < own_key;
				wa = mt_a_q;
			end else begin
				we = fr_v_q;
				wa = fr_a_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
	end

	// Scan trackers for add and lookup.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mt_v_q <= 1'b0;
			fr_v_q <= 1'b0;
			lo_v_q <= 1'b0;
			ab_v_q <= 1'b0;
		end else if (cmd.scan_init) begin
			mt_v_q <= 1'b0;
			fr_v_q <= 1'b0;
			lo_v_q <= 1'b0;
			ab_v_q <= 1'b0;
		end else if (rd_v_s1) begin
			if (req_q.cmd == CMD_ADD) begin
				if (rd_used && rd_hash == rep_h) mt_v_q <= 1'b1;
				if (!rd_used) fr_v_q <= 1'b1;
			end
			if (req_q.cmd == CMD_LOOKUP && rd_used) begin
				if (!lo_v_q || rd_hash < lo_h_q) lo_v_q <= 1'b1;
				if (rd_hash >= req_q.query_hash && (!ab_v_q || rd_hash < ab_h_q))
					ab_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_v_s1) begin
			if (req_q.cmd == CMD_ADD) begin
				if (rd_used && rd_hash == rep_h) begin
					mt_a_q <= addr_s1;
					mt_n_q <= rd_node;
				end
				if (!rd_used && !fr_v_q) fr_a_q <= addr_s1;
			end
			if (req_q.cmd == CMD_LOOKUP && rd_used) begin
				if (!lo_v_q || rd_hash < lo_h_q) begin
					lo_h_q <= rd_hash;
					lo_n_q <= rd_node;
				end
				if (rd_hash >= req_q.query_hash && (!ab_v_q || rd_hash < ab_h_q)) begin
					ab_h_q <= rd_hash;
					ab_n_q <= rd_node;
				end
			end
		end
	end

	// Result register and strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else done_q <= cmd.resp_load;
	end

	always_ff @(posedge clk) begin
		if (cmd.resp_load) begin
			resp_q.status    <= cmd.resp_status;
			resp_q.owner_key <= cmd.resp_owner ? own_key : 64'd0;
		end
	end

	assign stat.cmd      = req_q.cmd;
	assign stat.ptr_last = (ptr_q == PW'(MAX_POINTS - 1));
	assign stat.mul_rdy  = mul_rdy;
	assign stat.dup      = hit_any;
	assign stat.full     = !free_any;
	assign stat.absent   = !hit_any;
	assign stat.rep_done = (rep_q == rep_lim);
	assign stat.ring_hit = lo_v_q;
	assign done          = done_q;
	assign resp          = resp_q;

endmodule

### design/chr_ctrl.sv
module chr_ctrl import chr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  chr_stat_t stat,
	output logic      busy,
	output chr_cmd_t  cmd
);

	chr_state_t state_q;
	chr_state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_CLEAR;
		else state_q <= state_d;
	end

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_en = 1'b1;
				if (stat.ptr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					cmd.load_req = 1'b1;
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				unique case (stat.cmd)
					CMD_ADD: begin
						priority if (stat.dup) begin
							cmd.resp_load = 1'b1;
							cmd.resp_status = ST_DUP;
							state_d = S_IDLE;
						end else if (stat.full) begin
							cmd.resp_load = 1'b1;
							cmd.resp_status = ST_FULL;
							state_d = S_IDLE;
						end else begin
							cmd.node_add = 1'b1;
							cmd.mul_start = 1'b1;
							cmd.mul_seed = 1'b1;
							state_d = S_SEED;
						end
					end
					CMD_REMOVE: begin
						if (stat.absent) begin
							cmd.resp_load = 1'b1;
							cmd.resp_status = ST_ABSENT;
							state_d = S_IDLE;
						end else begin
							cmd.slot_found = 1'b1;
							cmd.scan_init = 1'b1;
							state_d = S_REM_SCAN;
						end
					end
					CMD_LOOKUP: begin
						cmd.scan_init = 1'b1;
						state_d = S_LKP_SCAN;
					end
					default: begin
						cmd.resp_load = 1'b1;
						cmd.resp_status = ST_OK;
						state_d = S_IDLE;
					end
				endcase
			end
			S_SEED: begin
				if (stat.mul_rdy) begin
					cmd.st_load = 1'b1;
					state_d = S_REP_CHECK;
				end
			end
			S_REP_CHECK: begin
				if (stat.rep_done) begin
					cmd.resp_load = 1'b1;
					cmd.resp_status = ST_OK;
					state_d = S_IDLE;
				end else begin
					cmd.scan_init = 1'b1;
					cmd.mul_start = 1'b1;
					state_d = S_REP_SCAN;
				end
			end
			S_REP_SCAN: begin
				cmd.scan_en = 1'b1;
				if (stat.ptr_last) state_d = S_REP_DRAIN;
			end
			S_REP_DRAIN: state_d = S_REP_WRITE;
			S_REP_WRITE: begin
				if (stat.mul_rdy) begin
					cmd.place_commit = 1'b1;
					cmd.st_load = 1'b1;
					state_d = S_REP_CHECK;
				end
			end
			S_REM_SCAN: begin
				cmd.scan_en = 1'b1;
				if (stat.ptr_last) state_d = S_REM_DRAIN;
			end
			S_REM_DRAIN: state_d = S_REM_FIN;
			S_REM_FIN: begin
				cmd.node_del = 1'b1;
				cmd.resp_load = 1'b1;
				cmd.resp_status = ST_OK;
				state_d = S_IDLE;
			end
			S_LKP_SCAN: begin
				cmd.scan_en = 1'b1;
				if (stat.ptr_last) state_d = S_LKP_DRAIN;
			end
			S_LKP_DRAIN: state_d = S_LKP_FIN;
			S_LKP_FIN: begin
				cmd.resp_load = 1'b1;
				cmd.resp_status = stat.ring_hit ? ST_OK : ST_EMPTY;
				cmd.resp_owner = stat.ring_hit;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign busy = (state_q != S_IDLE);

endmodule

### design/consistent_hash_ring_core.sv
// Consistent hash ring with virtual nodes.
// A command beat is taken when start is high and busy is low; req carries
// the command, node key, node hash and query hash. Each command gives one
// result beat on resp, marked by done for a single cycle; the receiver
// cannot stall, so results are never held back.
// The replica count register is written through cfg_valid/cfg_data and is
// always ready; write it only while the block is idle.
// Every lookup and remove sweeps the point memory once through its single
// read port. An add seeds the replica generator, then for each replica runs
// one sweep and the generator update. Errors and the unused command code
// answer without a sweep.
// Commands run one at a time; busy stays high until the result is loaded.
// After reset the block clears the point memory, one entry a cycle, with
// busy high; the replica count resets to 16.
module consistent_hash_ring_core import chr_pkg::*; #(
	parameter int MAX_NODES    = 16,
	parameter int MAX_REPLICAS = 64,
	parameter int MAX_POINTS   = 1024
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  chr_req_t   req,
	output logic       done,
	output chr_resp_t  resp,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [6:0] cfg_data
);

	logic [6:0] num_replicas_q;
	chr_cmd_t   cmd;
	chr_stat_t  stat;

	// Replica count register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) num_replicas_q <= 7'd16;
		else if (cfg_valid && cfg_ready) num_replicas_q <= cfg_data;
	end

	assign cfg_ready = 1'b1;

	chr_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.stat  (stat),
		.busy  (busy),
		.cmd   (cmd)
	);

	chr_datapath #(
		.MAX_NODES   (MAX_NODES),
		.MAX_REPLICAS(MAX_REPLICAS),
		.MAX_POINTS  (MAX_POINTS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.num_replicas(num_replicas_q),
		.cmd         (cmd),
		.stat        (stat),
		.done        (done),
		.resp        (resp)
	);

endmodule

### dv/tb_top.sv
`timescale 1ns / 100ps

import chr_pkg::*;

class chr_scoreboard;
	localparam int NODES  = 16;
	localparam int REPS   = 64;
	localparam int POINTS = 1024;

	// Mirror of the ring state and the replica count register.
	logic [6:0]  replicas;
	logic [63:0] key_tab [NODES];
	bit          key_live [NODES];
	logic [31:0] pt_hash [POINTS];
	logic [3:0]  pt_node [POINTS];
	bit          pt_live [POINTS];
	chr_resp_t   pending [$];
	int          errors;

	function void clear();
		replicas = 7'd16;
		errors = 0;
		foreach (key_live[i]) key_live[i] = 0;
		foreach (pt_live[i]) pt_live[i] = 0;
		pending.delete();
	endfunction

	function int find_key(logic [63:0] k);
		for (int i = 0; i < NODES; i++)
			if (key_live[i] && key_tab[i] == k) return i;
		return -1;
	endfunction

	// One step of the replica generator; returns the drawn ring point.
	function logic [31:0] draw(ref logic [63:0] st);
		logic [63:0] prev;
		logic [31:0] xs;
		logic [4:0]  rot;
		prev = st;
		st = prev * PCG_MULT + PCG_INC;
		xs = 32'(((prev >> 18) ^ prev) >> 27);
		rot = prev[63:59];
		return (xs >> rot) | (xs << ((32 - rot) & 31));
	endfunction

	function void put_point(logic [31:0] h, int slot, logic [63:0] k);
		int spare;
		spare = -1;
		for (int i = 0; i < POINTS; i++) begin
			if (pt_live[i]) begin
				if (pt_hash[i] == h) begin
					// Collision: the smaller key owns the point.
					if (k < key_tab[pt_node[i]]) pt_node[i] = 4'(slot);
					return;
				end
			end else if (spare < 0) begin
				spare = i;
			end
		end
		if (spare >= 0) begin
			pt_live[spare] = 1;
			pt_hash[spare] = h;
			pt_node[spare] = 4'(slot);
		end
	endfunction

	// Works out the answer to one accepted command beat.
	function void note_cmd(chr_req_t r);
		chr_resp_t   a;
		int          slot, cnt, lo, hi;
		logic [63:0] st;
		a.status = ST_OK;
		a.owner_key = '0;
		case (r.cmd)
			CMD_ADD: begin
				slot = -1;
				if (find_key(r.node_key) >= 0) begin
					a.status = ST_DUP;
				end else begin
					for (int i = NODES - 1; i >= 0; i--)
						if (!key_live[i]) slot = i;
					if (slot < 0) begin
						a.status = ST_FULL;
					end else begin
						key_live[slot] = 1;
						key_tab[slot] = r.node_key;
						cnt = replicas > REPS ? REPS : replicas;
						st = (64'(r.node_hash) + PCG_INC) * PCG_MULT + PCG_INC;
						for (int n = 0; n < cnt; n++)
							put_point(draw(st), slot, r.node_key);
					end
				end
			end
			CMD_REMOVE: begin
				slot = find_key(r.node_key);
				if (slot < 0) begin
					a.status = ST_ABSENT;
				end else begin
					for (int i = 0; i < POINTS; i++)
						if (pt_live[i] && pt_node[i] == slot) pt_live[i] = 0;
					key_live[slot] = 0;
				end
			end
			CMD_LOOKUP: begin
				lo = -1;
				hi = -1;
				for (int i = 0; i < POINTS; i++) begin
					if (!pt_live[i]) continue;
					if (lo < 0 || pt_hash[i] < pt_hash[lo]) lo = i;
					if (pt_hash[i] >= r.query_hash && (hi < 0 || pt_hash[i] < pt_hash[hi]))
						hi = i;
				end
				if (lo < 0) begin
					a.status = ST_EMPTY;
				end else begin
					// Wrap to the lowest point when nothing lies at or above the query.
					if (hi < 0) hi = lo;
					a.owner_key = key_tab[pt_node[hi]];
				end
			end
			default: ;
		endcase
		pending.push_back(a);
	endfunction

	task report(string msg);
		$display("mismatch: %s", msg);
		errors++;
	endtask

	task check_resp(chr_resp_t got);
		chr_resp_t want;
		if (pending.size() == 0) begin
			report($sformatf("unexpected result status=%0d owner=%h", got.status,
				got.owner_key));
			return;
		end
		want = pending.pop_front();
		if (got.status !== want.status)
			report($sformatf("status %0d, expected %0d", got.status, want.status));
		if (got.owner_key !== want.owner_key)
			report($sformatf("owner %h, expected %h", got.owner_key, want.owner_key));
	endtask
endclass

module tb_top;
	localparam int LIMIT = 20000000;

	logic       clk;
	logic       arst_n;
	logic       start;
	logic       busy;
	chr_req_t   req;
	logic       done;
	chr_resp_t  resp;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [6:0] cfg_data;

	chr_scoreboard ring;
	logic [63:0]   key_pool [24];
	logic [31:0]   hash_pool [6];
	int            cycles;

	consistent_hash_ring_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .resp(resp), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Result monitor and run watchdog.
	always @(posedge clk) begin
		cycles++;
		if (arst_n && done) ring.check_resp(resp);
		if (cycles > LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Presents one command beat and waits until it is taken.
	task issue(logic [1:0] c, logic [63:0] k, logic [31:0] nh, logic [31:0] qh);
		chr_req_t r;
		r.cmd = c;
		r.node_key = k;
		r.node_hash = nh;
		r.query_hash = qh;
		@(negedge clk);
		start <= 1'b1;
		req <= r;
		@(posedge clk);
		while (busy) @(posedge clk);
		ring.note_cmd(r);
	endtask

	task pause(int n);
		@(negedge clk);
		start <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	task drain();
		pause(0);
		while (ring.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// Replica count write, only with the block idle.
	task set_replicas(logic [6:0] v);
		drain();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		ring.replicas = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task clear_nodes();
		for (int i = 0; i < 16; i++)
			if (ring.key_live[i]) issue(CMD_REMOVE, ring.key_tab[i], 0, 0);
	endtask

	task random_phase(int count);
		int          burst, sel;
		logic [63:0] k;
		logic [31:0] h;
		burst = 0;
		for (int n = 0; n < count; n++) begin
			if (burst == 0) begin
				burst = $urandom_range(1, 8);
				if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 6));
			end
			burst--;
			k = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom} :
				key_pool[$urandom_range(0, 23)];
			h = ($urandom_range(0, 2) == 0) ? hash_pool[$urandom_range(0, 5)] : $urandom;
			sel = $urandom_range(0, 99);
			if (sel < 30) issue(CMD_ADD, k, h, $urandom);
			else if (sel < 52) issue(CMD_REMOVE, k, $urandom, $urandom);
			else if (sel < 96) issue(CMD_LOOKUP, {$urandom, $urandom}, $urandom, $urandom);
			else issue(CMD_RSVD, k, h, $urandom);
		end
	endtask

	initial begin
		ring = new;
		ring.clear();
		cycles = 0;
		start = 1'b0;
		req = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		arst_n = 1'b0;
		foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
		key_pool[0] = '0;
		key_pool[1] = '1;
		foreach (hash_pool[i]) hash_pool[i] = $urandom;
		hash_pool[0] = '0;
		hash_pool[1] = '1;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: empty ring, absent node, unknown command, default count.
		issue(CMD_LOOKUP, 0, 0, 32'h0);
		issue(CMD_REMOVE, 64'h1234, 0, 0);
		issue(CMD_RSVD, '1, '1, '1);
		issue(CMD_ADD, 64'd0, 32'h0, 0);
		issue(CMD_ADD, 64'd0, 32'h55, 0);
		issue(CMD_LOOKUP, 0, 0, 32'h0);
		issue(CMD_LOOKUP, 0, 0, 32'hFFFF_FFFF);
		// Same hash as another node: colliding points keep the smaller key.
		issue(CMD_ADD, 64'd7, 32'h0, 0);
		issue(CMD_ADD, '1, 32'hFFFF_FFFF, 0);
		issue(CMD_LOOKUP, 0, 0, 32'h8000_0000);
		issue(CMD_REMOVE, 64'd0, 0, 0);
		issue(CMD_LOOKUP, 0, 0, 32'h1);
		issue(CMD_REMOVE, 64'd7, 0, 0);
		issue(CMD_REMOVE, '1, 0, 0);
		issue(CMD_LOOKUP, 0, 0, 32'h0);

		// Zero replicas: the node exists but owns no point.
		set_replicas(7'd0);
		issue(CMD_ADD, 64'h99, 32'h3, 0);
		issue(CMD_LOOKUP, 0, 0, 32'h3);
		issue(CMD_REMOVE, 64'h99, 0, 0);

		// Fill the node table, then one more.
		set_replicas(7'd1);
		for (int i = 0; i < 17; i++) issue(CMD_ADD, 64'(i + 100), $urandom, 0);
		issue(CMD_LOOKUP, 0, 0, $urandom);
		clear_nodes();

		// Random phases over several replica counts.
		set_replicas(7'd2);
		random_phase(110);
		set_replicas(7'd0);
		random_phase(60);
		set_replicas(7'd4);
		random_phase(110);
		set_replicas(7'd1);
		random_phase(110);
		set_replicas(7'd3);
		random_phase(110);

		// Largest count, and a count above the maximum that is clamped.
		drain();
		clear_nodes();
		set_replicas(7'd64);
		issue(CMD_ADD, {$urandom, $urandom}, $urandom, 0);
		issue(CMD_LOOKUP, 0, 0, $urandom);
		set_replicas(7'd127);
		issue(CMD_ADD, {$urandom, $urandom}, $urandom, 0);
		issue(CMD_LOOKUP, 0, 0, $urandom);
		issue(CMD_LOOKUP, 0, 0, 32'hFFFF_FFFF);

		drain();
		if (ring.errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule
